/* src/pl0_lex_pkg.sv */
// ---------------------------------------------------------------------------
// PL/0 lexical scanner package
// Shared widths, character codes, token kinds, scanner modes and the
// structures passed between the scanner core and the token queue.
// ---------------------------------------------------------------------------
package pl0_lex_pkg;

   // Field widths
   localparam int CharW = 8;
   localparam int KindW = 5;
   localparam int LineW = 16;
   localparam int LenW  = 8;
   localparam int ValW  = 32;

   // Token queue geometry
   localparam int FifoDepth = 4;
   localparam int PtrW      = $clog2(FifoDepth);
   localparam int CntW      = $clog2(FifoDepth + 1);

   // Saturation limits
   localparam logic [LineW-1:0] LINE_MAX = '1;
   localparam logic [LenW-1:0]  LEN_MAX  = '1;

   // Character codes
   localparam logic [CharW-1:0] CH_HASH   = 8'h23;
   localparam logic [CharW-1:0] CH_NL     = 8'h0A;
   localparam logic [CharW-1:0] CH_TAB    = 8'h09;
   localparam logic [CharW-1:0] CH_VT     = 8'h0B;
   localparam logic [CharW-1:0] CH_FF     = 8'h0C;
   localparam logic [CharW-1:0] CH_CR     = 8'h0D;
   localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
   localparam logic [CharW-1:0] CH_LPAREN = 8'h28;
   localparam logic [CharW-1:0] CH_RPAREN = 8'h29;
   localparam logic [CharW-1:0] CH_STAR   = 8'h2A;
   localparam logic [CharW-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CharW-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CharW-1:0] CH_DOT    = 8'h2E;
   localparam logic [CharW-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
   localparam logic [CharW-1:0] CH_NINE   = 8'h39;
   localparam logic [CharW-1:0] CH_COLON  = 8'h3A;
   localparam logic [CharW-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CharW-1:0] CH_LT     = 8'h3C;
   localparam logic [CharW-1:0] CH_EQ     = 8'h3D;
   localparam logic [CharW-1:0] CH_GT     = 8'h3E;
   localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CharW-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CharW-1:0] CH_LOWER_Z = 8'h7A;

   typedef enum logic [KindW-1:0] {
      KIND_PLUS, KIND_MINUS, KIND_MULT, KIND_DIV, KIND_SEMI, KIND_COMMA,
      KIND_EQ, KIND_LPAREN, KIND_RPAREN, KIND_ASSIGN, KIND_LT, KIND_LE,
      KIND_NEQ, KIND_GT, KIND_GE, KIND_NUMBER, KIND_IDENT, KIND_DOT,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      MODE_START, MODE_NUM, MODE_IDENT, MODE_COLON, MODE_LESS,
      MODE_GREATER, MODE_ERROR
   } mode_type;

   typedef struct packed {
      kind_type         kind;
      logic [LineW-1:0] line;
      logic [LenW-1:0]  length;
      logic [ValW-1:0]  value;
      logic             last;
   } token_type;

   // Tokens produced by one byte, compacted into slot 0 first
   typedef struct packed {
      logic [1:0]      count;
      token_type [1:0] tok;
   } push_type;

endpackage

/* src/pl0_lex_ifs.sv */
// ---------------------------------------------------------------------------
// PL/0 scanner channels
// Valid/ready channels for source bytes and for tokens.
// ---------------------------------------------------------------------------
interface pl0_lex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface pl0_lex_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] token_line;
   logic [7:0]  token_length;
   logic [31:0] number_value;
   logic        last_of_run;

   modport source (output valid, output token_kind, output token_line,
                   output token_length, output number_value,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_line,
                   input token_length, input number_value,
                   input last_of_run, output ready);
endinterface

/* src/pl0_lex_core.sv */
// ---------------------------------------------------------------------------
// PL/0 scanner core
// Holds the scanner state and combinationally turns one accepted byte
// into zero, one or two tokens.
// ---------------------------------------------------------------------------
module pl0_lex_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_fire,
   input  logic [pl0_lex_pkg::CharW-1:0] char_in,
   output pl0_lex_pkg::push_type        push
);
   import pl0_lex_pkg::*;

   typedef struct packed {
      logic            emit;
      kind_type        kind;
      mode_type        mode;
      logic [LenW-1:0] length;
      logic [ValW-1:0] accum;
      logic            newline;
   } start_type;

   function automatic logic is_digit(input logic [CharW-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_letter(input logic [CharW-1:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   // Classify a byte seen from the start mode
   function automatic start_type scan_start(input logic [CharW-1:0] c);
      start_type s;
      s.emit    = 1'b1;
      s.kind    = KIND_ERROR;
      s.mode    = MODE_START;
      s.length  = '0;
      s.accum   = '0;
      s.newline = 1'b0;
      unique case (c)
         CH_PLUS:   s.kind = KIND_PLUS;
         CH_MINUS:  s.kind = KIND_MINUS;
         CH_STAR:   s.kind = KIND_MULT;
         CH_SLASH:  s.kind = KIND_DIV;
         CH_SEMI:   s.kind = KIND_SEMI;
         CH_COMMA:  s.kind = KIND_COMMA;
         CH_EQ:     s.kind = KIND_EQ;
         CH_LPAREN: s.kind = KIND_LPAREN;
         CH_RPAREN: s.kind = KIND_RPAREN;
         CH_DOT:    s.kind = KIND_DOT;
         CH_COLON: begin
            s.emit = 1'b0; s.mode = MODE_COLON; s.length = LenW'(1);
         end
         CH_LT: begin
            s.emit = 1'b0; s.mode = MODE_LESS; s.length = LenW'(1);
         end
         CH_GT: begin
            s.emit = 1'b0; s.mode = MODE_GREATER; s.length = LenW'(1);
         end
         CH_NL: begin
            s.emit = 1'b0; s.newline = 1'b1;
         end
         CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: s.emit = 1'b0;
         default: begin
            priority if (is_digit(c)) begin
               s.emit   = 1'b0;
               s.mode   = MODE_NUM;
               s.length = LenW'(1);
               s.accum  = ValW'(c - CH_ZERO);
            end else if (is_letter(c)) begin
               s.emit   = 1'b0;
               s.mode   = MODE_IDENT;
               s.length = LenW'(1);
            end else begin
               s.mode   = MODE_ERROR;
            end
         end
      endcase
      return s;
   endfunction

   mode_type         mode_ff, mode_in;
   logic [LineW-1:0] line_ff, line_in;
   logic [LenW-1:0]  len_ff, len_in;
   logic [ValW-1:0]  acc_ff, acc_in;

   start_type        st;
   logic             use_start;
   logic             tok0_valid;
   kind_type         tok0_kind;
   logic [LenW-1:0]  tok0_len;
   logic [ValW-1:0]  tok0_val;
   logic             tok1_valid;
   logic [LenW-1:0]  grow_len;
   logic [ValW+3:0]  acc_wide;
   logic [ValW-1:0]  acc_next;
   token_type        tok0, tok1;
   logic [1:0]       tok_count;

   // Length and decimal accumulator with saturation
   assign grow_len = (len_ff == LEN_MAX) ? len_ff : len_ff + LenW'(1);
   assign acc_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                     + (ValW+4)'(char_in - CH_ZERO);
   assign acc_next = (|acc_wide[ValW+3:ValW]) ? '1 : acc_wide[ValW-1:0];

   // Next state and pending-token decode
   always_comb begin
      st         = scan_start(char_in);
      mode_in    = mode_ff;
      line_in    = line_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      use_start  = 1'b0;
      tok0_valid = 1'b0;
      tok0_kind  = KIND_NUMBER;
      tok0_len   = len_ff;
      tok0_val   = '0;
      if (char_in == CH_HASH) begin
         mode_in = MODE_START;
         line_in = '0;
         len_in  = '0;
         acc_in  = '0;
      end else begin
         unique case (mode_ff)
            MODE_START: use_start = 1'b1;
            MODE_NUM: begin
               if (is_digit(char_in)) begin
                  len_in = grow_len;
                  acc_in = acc_next;
               end else begin
                  tok0_valid = 1'b1;
                  tok0_val   = acc_ff;
                  use_start  = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_digit(char_in) || is_letter(char_in)) begin
                  len_in = grow_len;
               end else begin
                  tok0_valid = 1'b1;
                  tok0_kind  = KIND_IDENT;
                  use_start  = 1'b1;
               end
            end
            MODE_COLON: begin
               tok0_valid = 1'b1;
               len_in     = '0;
               acc_in     = '0;
               if (char_in == CH_EQ) begin
                  tok0_kind = KIND_ASSIGN;
                  tok0_len  = LenW'(2);
                  mode_in   = MODE_START;
               end else begin
                  tok0_kind = KIND_ERROR;
                  tok0_len  = LenW'(1);
                  mode_in   = MODE_ERROR;
               end
            end
            MODE_LESS: begin
               tok0_valid = 1'b1;
               if (char_in == CH_EQ || char_in == CH_GT) begin
                  tok0_kind = (char_in == CH_EQ) ? KIND_LE : KIND_NEQ;
                  tok0_len  = LenW'(2);
                  len_in    = '0;
                  acc_in    = '0;
                  mode_in   = MODE_START;
               end else begin
                  tok0_kind = KIND_LT;
                  tok0_len  = LenW'(1);
                  use_start = 1'b1;
               end
            end
            MODE_GREATER: begin
               tok0_valid = 1'b1;
               if (char_in == CH_EQ) begin
                  tok0_kind = KIND_GE;
                  tok0_len  = LenW'(2);
                  len_in    = '0;
                  acc_in    = '0;
                  mode_in   = MODE_START;
               end else begin
                  tok0_kind = KIND_GT;
                  tok0_len  = LenW'(1);
                  use_start = 1'b1;
               end
            end
            default: mode_in = MODE_ERROR;   // sticky error
         endcase
         if (use_start) begin
            mode_in = st.mode;
            len_in  = st.length;
            acc_in  = st.accum;
            if (st.newline && line_ff != LINE_MAX) begin
               line_in = line_ff + LineW'(1);
            end
         end
      end
   end

   // Token assembly; second token always comes from the start-mode scan
   assign tok1_valid = use_start && st.emit;
   assign tok_count  = {1'b0, tok0_valid} + {1'b0, tok1_valid};

   always_comb begin
      tok1.kind   = st.kind;
      tok1.line   = line_ff;
      tok1.length = LenW'(1);
      tok1.value  = '0;
      tok1.last   = 1'b1;
      tok0.kind   = tok0_kind;
      tok0.line   = line_ff;
      tok0.length = tok0_len;
      tok0.value  = tok0_val;
      tok0.last   = !tok1_valid;
      push.count  = in_fire ? tok_count : 2'd0;
      push.tok[0] = tok0_valid ? tok0 : tok1;
      push.tok[1] = tok1;
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         line_ff <= '0;
         len_ff  <= '0;
         acc_ff  <= '0;
      end else if (in_fire) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

/* src/pl0_lex_fifo.sv */
// ---------------------------------------------------------------------------
// PL/0 scanner token queue
// Small register queue taking up to two tokens a cycle and presenting one
// token a cycle on the result channel while the channel is ready.
// ---------------------------------------------------------------------------
module pl0_lex_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  pl0_lex_pkg::push_type push,
   output logic                  space_ok,
   pl0_lex_rsp_if.source         rsp_chan
);
   import pl0_lex_pkg::*;

   token_type         mem_ff [FifoDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [PtrW-1:0]   wr_next;
   logic              pop;
   token_type         head;

   assign wr_next  = wr_ptr_ff + PtrW'(1);
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign space_ok = (count_ff <= CntW'(FifoDepth - 2));

   // Pointer and occupancy update
   assign wr_ptr_in = wr_ptr_ff + PtrW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff + CntW'(push.count) - CntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.tok[0];
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.tok[1];
      end
   end

   // Head of queue drives the result channel
   assign head                  = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.token_line   = head.line;
   assign rsp_chan.token_length = head.length;
   assign rsp_chan.number_value = head.value;
   assign rsp_chan.last_of_run  = head.last;

endmodule

/* src/pl0_lexical_scanner.sv */
// ---------------------------------------------------------------------------
// PL/0 lexical scanner
// Scans PL/0 source one byte per transaction and emits tokens with kind,
// line, length and decimal value.
//
//   Channel    Direction  Transaction
//   req_chan   in         one source byte (char_in)
//   rsp_chan   out        one token; last_of_run marks the last per byte
//
// One byte is accepted per cycle while the queue has room; its tokens are
// written to a four-entry queue in the same cycle and leave it one per
// cycle while rsp_chan is ready. Input ready depends only on queue
// occupancy: room for two tokens. The two tokens of one byte leave one
// at a time by the single result port of the queue. Synchronous reset
// clears scanner state and empties the queue; '#' clears the scanner in band.
// ---------------------------------------------------------------------------
module pl0_lexical_scanner (
   input logic           clock,
   input logic           reset,
   pl0_lex_req_if.sink   req_chan,
   pl0_lex_rsp_if.source rsp_chan
);
   import pl0_lex_pkg::*;

   logic     in_fire;
   logic     space_ok;
   push_type push;

   assign req_chan.ready = space_ok;
   assign in_fire        = req_chan.valid && space_ok;

   // Scanner state and token decode
   pl0_lex_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .char_in (req_chan.char_in),
      .push    (push)
   );

   // Token queue
   pl0_lex_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .space_ok (space_ok),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   // Tokens are only produced by an accepted byte
   a_push_needs_fire: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> in_fire)
      else $error("token pushed without an accepted byte");

   // A pair of tokens carries the end-of-run mark on the second only
   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (!push.tok[0].last && push.tok[1].last))
      else $error("bad end-of-run marking on token pair");

   // A single token is the last of its run
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd1) |-> push.tok[0].last)
      else $error("single token not marked last of run");

   // Reset empties the queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid straight after reset");
`endif

endmodule
